FILE: hw/rtl/rtad_pkg.sv
// Shared types and constants of the range trie address decoder.
package rtad_pkg;

    // Node memory size and the bound on the number of nodes one walk may visit.
    localparam int TREE_DEPTH   = 4096;
    localparam int MAX_STEPS    = 64;
    localparam int ADDR_W       = $clog2(TREE_DEPTH);
    localparam int STEP_W       = $clog2(MAX_STEPS + 1);

    // Field widths of the beats.
    localparam int NODE_INDEX_W = 12;
    localparam int WORD_W       = 32;
    localparam int LEAF_CODE_W  = 24;
    localparam int TYPE_CODE_W  = 6;
    localparam int ITEM_W       = 16;

    // A raw node index before wrapping: a child step reaches below
    // TREE_DEPTH + 64 and a skip index below 65536.
    localparam int RAW_W        = 17;

    // Depth of the queue between front and back.
    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);
    localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_WRITTEN  = 3'd0,
        ST_NO_MATCH = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_REFUSED  = 3'd3,
        ST_FUNC     = 3'd4,
        ST_DATA     = 3'd5,
        ST_LIMIT    = 3'd6
    } status_t;

    // One classified item as it waits in the queue.
    typedef struct packed {
        logic                    lookup;
        logic                    wr_en;
        logic [NODE_INDEX_W-1:0] index;
        logic [WORD_W-1:0]       data;
        logic                    set_req;
    } item_t;

endpackage

FILE: hw/rtl/rtad_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rtad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/rtad_front.sv
// Front end: takes input beats, classifies them and pushes them into the queue.
module rtad_front (
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic                              kind,
    input  logic [rtad_pkg::NODE_INDEX_W-1:0] node_index,
    input  logic [rtad_pkg::WORD_W-1:0]       node_word,
    input  logic [rtad_pkg::WORD_W-1:0]       address,
    input  logic                              set_request,
    input  logic                              q_full,
    output logic                              q_push,
    output rtad_pkg::item_t                   q_item
);
    import rtad_pkg::*;

    localparam int CMP_W = (NODE_INDEX_W > ADDR_W ? NODE_INDEX_W : ADDR_W) + 1;

    logic index_in_range;

    // A write beyond the end of the node memory is still answered, but stores nothing.
    assign index_in_range = CMP_W'(node_index) < CMP_W'(TREE_DEPTH);

    assign item_ready = !q_full;
    assign q_push     = item_valid && !q_full;

    always_comb
    begin
        q_item.lookup  = kind;
        q_item.wr_en   = !kind && index_in_range;
        q_item.index   = node_index;
        q_item.data    = kind ? address : node_word;
        q_item.set_req = set_request;
    end

endmodule

FILE: hw/rtl/rtad_queue.sv
// Short first-in first-out queue of classified items between front and back.
module rtad_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rtad_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output rtad_pkg::item_t head_item
);
    import rtad_pkg::*;

    item_t              slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               do_push;
    logic               do_pop;

    assign full      = count_reg == Q_CNT_W'(Q_DEPTH);
    assign not_empty = count_reg != '0;
    assign head_item = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hw/rtl/rtad_back.sv
// Back end: performs node writes, walks the trie and classifies the leaf reached.
module rtad_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_not_empty,
    input  rtad_pkg::item_t                  q_head,
    output logic                             q_pop,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [2:0]                       status,
    output logic [rtad_pkg::LEAF_CODE_W-1:0] leaf_code,
    output logic [rtad_pkg::TYPE_CODE_W-1:0] type_code,
    output logic [rtad_pkg::ITEM_W-1:0]      func_item,
    output logic                             is_set
);
    import rtad_pkg::*;

    // Reciprocal of the depth for the modulo reduction of a raw index.
    localparam int RECIP_SHIFT = 34;
    localparam int RECIP_W     = 31;
    localparam int PROD_W      = RAW_W + RECIP_W;
    localparam int QUO_W       = PROD_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / TREE_DEPTH);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EVAL   = 6'b000010,
        S_WRAP_Q = 6'b000100,
        S_WRAP_R = 6'b001000,
        S_LEAF   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [STEP_W-1:0]      steps_reg;
    logic [STEP_W-1:0]      steps_next;

    logic [ADDR_W-1:0]      cur_reg;
    logic [ADDR_W-1:0]      cur_next;
    logic [RAW_W-1:0]       raw_reg;
    logic [RAW_W-1:0]       raw_next;
    logic [QUO_W-1:0]       quo_reg;
    logic [QUO_W-1:0]       quo_next;
    logic                   done_reg;
    logic                   done_next;
    logic [WORD_W-1:0]      addr_reg;
    logic [WORD_W-1:0]      addr_next;
    logic                   set_reg;
    logic                   set_next;

    status_t                res_status_reg;
    status_t                res_status_next;
    logic [LEAF_CODE_W-1:0] res_code_reg;
    logic [LEAF_CODE_W-1:0] res_code_next;
    logic [TYPE_CODE_W-1:0] res_type_reg;
    logic [TYPE_CODE_W-1:0] res_type_next;
    logic [ITEM_W-1:0]      res_item_reg;
    logic [ITEM_W-1:0]      res_item_next;
    logic                   res_set_reg;
    logic                   res_set_next;

    status_t                out_status_reg;
    logic [LEAF_CODE_W-1:0] out_code_reg;
    logic [TYPE_CODE_W-1:0] out_type_reg;
    logic [ITEM_W-1:0]      out_item_reg;
    logic                   out_set_reg;
    logic                   out_load;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic                   ram_re;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [WORD_W-1:0]      ram_rdata;

    // Node decode.
    logic [5:0]             node_start;
    logic [5:0]             node_count;
    logic [6:0]             node_end;
    logic [15:0]            field_val;
    logic                   node_match;
    logic [5:0]             node_offset;
    logic [RAW_W-1:0]       child_raw;
    logic [STEP_W-1:0]      steps_inc;

    // Index wrap.
    logic [PROD_W-1:0]      recip_prod;
    logic [31:0]            quo_times_depth;
    logic [31:0]            rem_full;
    logic [31:0]            rem_fixed;

    rtad_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TREE_DEPTH)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (q_head.data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        node_start = ram_rdata[21:16];
        node_count = ram_rdata[27:22];
        node_end   = 7'(node_start) + 7'(node_count);
        unique case (ram_rdata[29:28])
            2'd0:    field_val = 16'(addr_reg[29:26]);
            2'd1:    field_val = 16'(addr_reg[25:23]);
            2'd2:    field_val = 16'(addr_reg[21:16]);
            default: field_val = addr_reg[15:0];
        endcase
        node_match  = (field_val >= 16'(node_start)) && (field_val < 16'(node_end));
        node_offset = 6'(field_val - 16'(node_start));
        child_raw   = RAW_W'(cur_reg) + RAW_W'(node_offset) + RAW_W'(1);
        steps_inc   = steps_reg + 1'b1;
    end

    // Modulo of the raw index: the reciprocal estimate is low by at most one.
    always_comb
    begin
        recip_prod      = PROD_W'(raw_reg) * PROD_W'(RECIP);
        quo_times_depth = 32'(quo_reg) * 32'(TREE_DEPTH);
        rem_full        = 32'(raw_reg) - quo_times_depth;
        rem_fixed       = (rem_full >= 32'(TREE_DEPTH)) ? rem_full - 32'(TREE_DEPTH) : rem_full;
    end

    assign out_load = (state_reg == S_FINISH) && (!out_valid_reg || result_ready);

    always_comb
    begin
        state_next      = state_reg;
        steps_next      = steps_reg;
        cur_next        = cur_reg;
        raw_next        = raw_reg;
        quo_next        = quo_reg;
        done_next       = done_reg;
        addr_next       = addr_reg;
        set_next        = set_reg;
        res_status_next = res_status_reg;
        res_code_next   = res_code_reg;
        res_type_next   = res_type_reg;
        res_item_next   = res_item_reg;
        res_set_next    = res_set_reg;
        q_pop           = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = ADDR_W'(q_head.index);
        ram_re          = 1'b0;
        ram_raddr       = '0;
        out_valid_next  = out_valid_reg && !result_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop           = 1'b1;
                    res_status_next = ST_WRITTEN;
                    res_code_next   = '0;
                    res_type_next   = '0;
                    res_item_next   = '0;
                    res_set_next    = 1'b0;
                    if (q_head.lookup)
                    begin
                        addr_next  = q_head.data;
                        set_next   = q_head.set_req;
                        cur_next   = '0;
                        steps_next = '0;
                        done_next  = 1'b0;
                        ram_re     = 1'b1;
                        state_next = S_EVAL;
                    end
                    else
                    begin
                        ram_we     = q_head.wr_en;
                        state_next = S_FINISH;
                    end
                end
            end
            S_EVAL:
            begin
                steps_next = steps_inc;
                if (node_match)
                begin
                    raw_next  = child_raw;
                    done_next = ram_rdata[31];
                    if (!ram_rdata[31] && steps_inc == STEP_W'(MAX_STEPS))
                    begin
                        res_status_next = ST_LIMIT;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_WRAP_Q;
                    end
                end
                else if (!ram_rdata[30])
                begin
                    raw_next = RAW_W'(ram_rdata[15:0]);
                    if (steps_inc == STEP_W'(MAX_STEPS))
                    begin
                        res_status_next = ST_LIMIT;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_WRAP_Q;
                    end
                end
                else
                begin
                    res_status_next = ST_NO_MATCH;
                    state_next      = S_FINISH;
                end
            end
            S_WRAP_Q:
            begin
                quo_next   = recip_prod[RECIP_SHIFT +: QUO_W];
                state_next = S_WRAP_R;
            end
            S_WRAP_R:
            begin
                cur_next   = ADDR_W'(rem_fixed);
                ram_re     = 1'b1;
                ram_raddr  = ADDR_W'(rem_fixed);
                state_next = done_reg ? S_LEAF : S_EVAL;
            end
            S_LEAF:
            begin
                if (ram_rdata == '0)
                begin
                    res_status_next = ST_EMPTY;
                end
                else if (ram_rdata[31])
                begin
                    if (set_reg && !ram_rdata[30])
                    begin
                        res_status_next = ST_REFUSED;
                    end
                    else
                    begin
                        res_status_next = ST_FUNC;
                        res_code_next   = ram_rdata[23:0];
                        res_item_next   = addr_reg[15:0];
                        res_set_next    = set_reg;
                    end
                end
                else
                begin
                    res_status_next = ST_DATA;
                    res_code_next   = ram_rdata[23:0];
                    res_type_next   = ram_rdata[29:24];
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            steps_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            steps_reg     <= steps_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        raw_reg        <= raw_next;
        quo_reg        <= quo_next;
        addr_reg       <= addr_next;
        set_reg        <= set_next;
        res_status_reg <= res_status_next;
        res_code_reg   <= res_code_next;
        res_type_reg   <= res_type_next;
        res_item_reg   <= res_item_next;
        res_set_reg    <= res_set_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_code_reg   <= res_code_reg;
            out_type_reg   <= res_type_reg;
            out_item_reg   <= res_item_reg;
            out_set_reg    <= res_set_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = out_status_reg;
    assign leaf_code    = out_code_reg;
    assign type_code    = out_type_reg;
    assign func_item    = out_item_reg;
    assign is_set       = out_set_reg;

    // The walk never counts past its bound.
    a_steps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        steps_reg <= STEP_W'(MAX_STEPS))
        else $error("walk step count exceeds its bound");

    // A wrapped node index always lies inside the node memory.
    a_raddr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (32'(ram_raddr) < 32'(TREE_DEPTH)))
        else $error("node read address beyond the memory");

    // A node is evaluated only in the cycle after its read was issued.
    a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL || state_reg == S_LEAF) |-> $past(ram_re))
        else $error("node evaluated without a preceding read");

    // A new result appears only from the finishing state.
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside the finishing state");

endmodule

FILE: hw/rtl/range_trie_address_decoder_unit.sv
// Top level of the range trie address decoder: front end, queue and back end.
// The back end works on one item at a time; each visited node takes a registered
// node memory read evaluated in S_EVAL, then index wrapping in S_WRAP_Q and S_WRAP_R.
// Reset clears the control state only; the node memory is not cleared and holds
// undefined words until written.
module range_trie_address_decoder_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic                              kind,
    input  logic [rtad_pkg::NODE_INDEX_W-1:0] node_index,
    input  logic [rtad_pkg::WORD_W-1:0]       node_word,
    input  logic [rtad_pkg::WORD_W-1:0]       address,
    input  logic                              set_request,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [2:0]                        status,
    output logic [rtad_pkg::LEAF_CODE_W-1:0]  leaf_code,
    output logic [rtad_pkg::TYPE_CODE_W-1:0]  type_code,
    output logic [rtad_pkg::ITEM_W-1:0]       func_item,
    output logic                              is_set
);
    import rtad_pkg::*;

    // Classified beats pass from the front end to the back end through the queue,
    // so the input side keeps accepting, until the queue is full, while a walk is in
    // progress or a result waits in the output register.
    logic  q_full;
    logic  q_push;
    item_t q_push_item;
    logic  q_pop;
    logic  q_not_empty;
    item_t q_head;

    // The front end decides whether a beat is a write or a lookup and whether
    // a write index lies inside the node memory.
    rtad_front u_front (
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .kind        (kind),
        .node_index  (node_index),
        .node_word   (node_word),
        .address     (address),
        .set_request (set_request),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (q_push_item)
    );

    rtad_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (q_head)
    );

    // The back end owns the node memory, so writes and lookups take effect in
    // the order in which their beats were accepted.
    rtad_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .leaf_code    (leaf_code),
        .type_code    (type_code),
        .func_item    (func_item),
        .is_set       (is_set)
    );

endmodule

FILE: test/tb_range_trie_address_decoder_unit.sv
// Self-checking testbench of the range trie address decoder: directed table, then random walks.
module tb_range_trie_address_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rtad_pkg::*;

    // Kind of an input beat, as carried on the kind port.
    typedef enum bit {
        KIND_WRITE  = 1'b0,
        KIND_LOOKUP = 1'b1
    } item_kind_t;

    // Which address field a node compares against (node bits 29:28).
    typedef enum logic [1:0] {
        SEL_BITS_29_26 = 2'd0,
        SEL_BITS_25_23 = 2'd1,
        SEL_BITS_21_16 = 2'd2,
        SEL_BITS_15_0  = 2'd3
    } field_sel_t;

    // How a walk through the trie came to an end.
    typedef enum {
        WALK_MISS,
        WALK_LIMIT,
        WALK_LEAF
    } walk_end_t;

    // One result beat, field by field.
    typedef struct packed {
        status_t                status;
        logic [LEAF_CODE_W-1:0] leaf_code;
        logic [TYPE_CODE_W-1:0] type_code;
        logic [ITEM_W-1:0]      func_item;
        logic                   is_set;
    } decode_result_t;

    // One row of the directed table. Where typed is set, the result column is
    // the answer to check; otherwise the row is checked against the decoder model.
    typedef struct packed {
        item_kind_t              kind;
        logic [NODE_INDEX_W-1:0] index;
        logic [WORD_W-1:0]       word;
        logic [WORD_W-1:0]       addr;
        logic                    set_req;
        bit                      typed;
        decode_result_t          result;
    } stim_row_t;

    localparam decode_result_t WRITE_ACK = '{ST_WRITTEN, 24'd0, 6'd0, 16'd0, 1'b0};

    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES  = 300;
    // Drain time, sized to cover a lookup that runs to the step limit.
    localparam int DRAIN_CYCLES = 3 * MAX_STEPS + 16;

    logic                    clk;
    logic                    rst_n;
    logic                    item_valid;
    logic                    item_ready;
    logic                    kind;
    logic [NODE_INDEX_W-1:0] node_index;
    logic [WORD_W-1:0]       node_word;
    logic [WORD_W-1:0]       address;
    logic                    set_request;
    logic                    result_valid;
    logic                    result_ready;
    logic [2:0]              status;
    logic [LEAF_CODE_W-1:0]  leaf_code;
    logic [TYPE_CODE_W-1:0]  type_code;
    logic [ITEM_W-1:0]       func_item;
    logic                    is_set;

    // Our own copy of the node memory, with a note of which entries hold a word.
    // The block's memory is undefined until written, so no lookup may ever be
    // sent whose walk would read an entry that this map still shows as empty.
    logic [WORD_W-1:0] trie_nodes   [TREE_DEPTH];
    bit                trie_written [TREE_DEPTH];

    // Decodes predicted for beats already accepted, oldest first.
    decode_result_t decodes_in_flight [$];

    int decode_errors = 0;
    int items_sent    = 0;
    int rx_count      = 0;
    bit random_phase  = 1'b0;
    bit sink_hold     = 1'b0;

    // Directed beats. The first rows exercise an empty range that loops back on
    // itself until the step limit, and a terminal node that misses. Then a single
    // node that matches on its last bit leads to leaf node 1, which is rewritten
    // as an empty leaf, a function leaf that cannot be set, a settable one with
    // the widest code, and a data leaf with every code bit high. Node 4095 is
    // reached through a skip index that wraps, and its child step wraps back to
    // node 0. The last rows build a two-level walk on the middle address fields.
    stim_row_t directed_rows [23] = '{
        '{KIND_WRITE,  12'h000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, WRITE_ACK},
        '{KIND_LOOKUP, 12'h000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1,
          '{ST_LIMIT, 24'd0, 6'd0, 16'd0, 1'b0}},
        '{KIND_WRITE,  12'h000, 32'h4000_0000, 32'h0000_0000, 1'b0, 1'b1, WRITE_ACK},
        '{KIND_LOOKUP, 12'h000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1,
          '{ST_NO_MATCH, 24'd0, 6'd0, 16'd0, 1'b0}},
        '{KIND_WRITE,  12'h001, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, WRITE_ACK},
        '{KIND_WRITE,  12'h000, 32'hB045_0000, 32'h0000_0000, 1'b0, 1'b1, WRITE_ACK},
        '{KIND_LOOKUP, 12'h000, 32'h0000_0000, 32'h0000_0005, 1'b0, 1'b1,
          '{ST_EMPTY, 24'd0, 6'd0, 16'd0, 1'b0}},
        '{KIND_LOOKUP, 12'h000, 32'h0000_0000, 32'h0000_0006, 1'b0, 1'b0, WRITE_ACK},
        '{KIND_WRITE,  12'h001, 32'h80AB_CDEF, 32'h0000_0000, 1'b0, 1'b1, WRITE_ACK},
        '{KIND_LOOKUP, 12'h000, 32'h0000_0000, 32'h1234_0005, 1'b0, 1'b1,
          '{ST_FUNC, 24'hAB_CDEF, 6'd0, 16'h0005, 1'b0}},
        '{KIND_LOOKUP, 12'h000, 32'h0000_0000, 32'h1234_0005, 1'b1, 1'b1,
          '{ST_REFUSED, 24'd0, 6'd0, 16'd0, 1'b0}},
        '{KIND_WRITE,  12'h001, 32'hC0FF_FFFF, 32'h0000_0000, 1'b0, 1'b1, WRITE_ACK},
        '{KIND_LOOKUP, 12'h000, 32'h0000_0000, 32'hFFFF_0005, 1'b1, 1'b1,
          '{ST_FUNC, 24'hFF_FFFF, 6'd0, 16'h0005, 1'b1}},
        '{KIND_WRITE,  12'h001, 32'h3FFF_FFFF, 32'h0000_0000, 1'b0, 1'b1, WRITE_ACK},
        '{KIND_LOOKUP, 12'h000, 32'h0000_0000, 32'h0000_0005, 1'b0, 1'b1,
          '{ST_DATA, 24'hFF_FFFF, 6'h3F, 16'd0, 1'b0}},
        '{KIND_WRITE,  12'hFFF, 32'hB040_0000, 32'h0000_0000, 1'b0, 1'b1, WRITE_ACK},
        '{KIND_WRITE,  12'h000, 32'h3000_FFFF, 32'h0000_0000, 1'b0, 1'b1, WRITE_ACK},
        '{KIND_LOOKUP, 12'h000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, WRITE_ACK},
        '{KIND_WRITE,  12'h002, 32'h9083_0000, 32'h0000_0000, 1'b0, 1'b1, WRITE_ACK},
        '{KIND_WRITE,  12'h004, 32'h0A00_0042, 32'h0000_0000, 1'b0, 1'b1, WRITE_ACK},
        '{KIND_WRITE,  12'h000, 32'h6110_0000, 32'h0000_0000, 1'b0, 1'b1, WRITE_ACK},
        '{KIND_LOOKUP, 12'h000, 32'h0000_0000, 32'h0211_0000, 1'b0, 1'b0, WRITE_ACK},
        '{KIND_LOOKUP, 12'h000, 32'h0000_0000, 32'h0020_0000, 1'b1, 1'b0, WRITE_ACK}
    };

    range_trie_address_decoder_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .kind         (kind),
        .node_index   (node_index),
        .node_word    (node_word),
        .address      (address),
        .set_request  (set_request),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .leaf_code    (leaf_code),
        .type_code    (type_code),
        .func_item    (func_item),
        .is_set       (is_set)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Walks the trie from node 0 for one address. With guide set, each node
    // that has a range usually rewrites its address field to a value inside the
    // range, so that random addresses get past the first nodes. The first entry
    // read that was never written is reported, and whether it was the leaf.
    function automatic walk_end_t walk_trie(inout logic [WORD_W-1:0] addr, input bit guide,
                                            output int leaf_idx, output int gap_idx,
                                            output bit gap_at_leaf);
        int                cur;
        int                first;
        int                span;
        int                v;
        logic [WORD_W-1:0] w;
        field_sel_t        sel;
        cur         = 0;
        leaf_idx    = 0;
        gap_idx     = -1;
        gap_at_leaf = 1'b0;
        for (int n = 0; n < MAX_STEPS; n++)
        begin
            if (!trie_written[cur] && gap_idx < 0)
                gap_idx = cur;
            w     = trie_nodes[cur];
            sel   = field_sel_t'(w[29:28]);
            first = w[21:16];
            span  = w[27:22];
            if (guide && span > 0 && $urandom_range(0, 9) < 8)
            begin
                v = first + $urandom_range(0, span - 1);
                case (sel)
                    SEL_BITS_29_26: addr[29:26] = v[3:0];
                    SEL_BITS_25_23: addr[25:23] = v[2:0];
                    SEL_BITS_21_16: addr[21:16] = v[5:0];
                    default:        addr[15:0]  = v[15:0];
                endcase
            end
            case (sel)
                SEL_BITS_29_26: v = addr[29:26];
                SEL_BITS_25_23: v = addr[25:23];
                SEL_BITS_21_16: v = addr[21:16];
                default:        v = addr[15:0];
            endcase
            if (v >= first && v < first + span)
            begin
                // A match steps to the child; past the end of memory it wraps.
                cur = (cur + v - first + 1) % TREE_DEPTH;
                if (w[31])
                begin
                    leaf_idx = cur;
                    if (!trie_written[cur] && gap_idx < 0)
                    begin
                        gap_idx     = cur;
                        gap_at_leaf = 1'b1;
                    end
                    return WALK_LEAF;
                end
            end
            else if (!w[30])
                cur = w[15:0] % TREE_DEPTH;
            else
                return WALK_MISS;
        end
        return WALK_LIMIT;
    endfunction

    // Applies one accepted beat to our copy of the memory and works out the
    // result beat that the block must give for it.
    function automatic decode_result_t decode_item(input item_kind_t k,
                                                   input logic [NODE_INDEX_W-1:0] idx,
                                                   input logic [WORD_W-1:0] word,
                                                   input logic [WORD_W-1:0] addr,
                                                   input logic setr);
        decode_result_t    r;
        logic [WORD_W-1:0] probe;
        logic [WORD_W-1:0] leaf;
        walk_end_t         fin;
        int                leaf_idx;
        int                gap_idx;
        bit                gap_at_leaf;
        r     = WRITE_ACK;
        probe = addr;
        if (k == KIND_WRITE)
        begin
            trie_nodes[idx]   = word;
            trie_written[idx] = 1'b1;
            return r;
        end
        fin = walk_trie(probe, 1'b0, leaf_idx, gap_idx, gap_at_leaf);
        if (fin == WALK_MISS)
            r.status = ST_NO_MATCH;
        else if (fin == WALK_LIMIT)
            r.status = ST_LIMIT;
        else
        begin
            leaf = trie_nodes[leaf_idx];
            if (leaf == '0)
                r.status = ST_EMPTY;
            else if (leaf[31])
            begin
                // Function leaf: bit 30 says whether a set may be dispatched.
                if (setr && !leaf[30])
                    r.status = ST_REFUSED;
                else
                begin
                    r.status    = ST_FUNC;
                    r.leaf_code = leaf[23:0];
                    r.func_item = addr[15:0];
                    r.is_set    = setr;
                end
            end
            else
            begin
                r.status    = ST_DATA;
                r.leaf_code = leaf[23:0];
                r.type_code = leaf[29:24];
            end
        end
        return r;
    endfunction

    // A plausible node word: ranges mostly sized to fit the chosen field and
    // skip indices mostly near the root, so that walks stay short and varied.
    function automatic logic [WORD_W-1:0] fresh_node_word(input bit as_leaf);
        logic [WORD_W-1:0] w;
        int                first_max;
        int                span_max;
        w = $urandom;
        if (as_leaf)
        begin
            case ($urandom_range(0, 3))
                0: w = '0;
                1: w[31] = 1'b1;
                default:
                begin
                    w[31] = 1'b0;
                    if (w == '0)
                        w = 32'd1;
                end
            endcase
            return w;
        end
        case (field_sel_t'(w[29:28]))
            SEL_BITS_29_26:
            begin
                first_max = 15;
                span_max  = 6;
            end
            SEL_BITS_25_23:
            begin
                first_max = 7;
                span_max  = 4;
            end
            SEL_BITS_21_16:
            begin
                first_max = 63;
                span_max  = 8;
            end
            default:
            begin
                first_max = 63;
                span_max  = 63;
            end
        endcase
        w[30] = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 7) != 0)
        begin
            w[21:16] = 6'($urandom_range(0, first_max));
            w[27:22] = ($urandom_range(0, 7) == 0) ? 6'd0 : 6'($urandom_range(1, span_max));
        end
        if ($urandom_range(0, 3) != 0)
            w[15:0] = 16'($urandom_range(0, 96));
        return w;
    endfunction

    // Offers one beat after a random pause, with stretches of none, and holds it until
    // accepted. The decode is worked out in this same process at the accepting edge,
    // so the memory copy is always up to date before the next beat is chosen.
    task automatic send_item(input item_kind_t k, input logic [NODE_INDEX_W-1:0] idx,
                             input logic [WORD_W-1:0] word, input logic [WORD_W-1:0] addr,
                             input logic setr, input bit typed, input decode_result_t known);
        int             gap;
        decode_result_t r;
        gap = (items_sent % 64 < 16) ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        kind        <= k;
        node_index  <= idx;
        node_word   <= word;
        address     <= addr;
        set_request <= setr;
        item_valid  <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        r = decode_item(k, idx, word, addr, setr);
        decodes_in_flight.push_back(typed ? known : r);
        items_sent++;
    endtask

    task automatic send_write(input logic [NODE_INDEX_W-1:0] idx, input logic [WORD_W-1:0] word);
        send_item(KIND_WRITE, idx, word, $urandom, 1'($urandom), 1'b0, WRITE_ACK);
    endtask

    // Stimulus: reset, the directed table, then random beats.
    initial
    begin
        logic [WORD_W-1:0] addr;
        logic              setr;
        bit                guiding;
        bit                gap_at_leaf;
        int                pick;
        int                leaf_idx;
        int                gap_idx;
        walk_end_t         fin;
        rst_n       <= 1'b0;
        item_valid  <= 1'b0;
        kind        <= 1'b0;
        node_index  <= '0;
        node_word   <= '0;
        address     <= '0;
        set_request <= 1'b0;
        foreach (trie_nodes[i])
        begin
            trie_nodes[i]   = '0;
            trie_written[i] = 1'b0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].kind, directed_rows[i].index, directed_rows[i].word,
                      directed_rows[i].addr, directed_rows[i].set_req, directed_rows[i].typed,
                      directed_rows[i].result);

        random_phase <= 1'b1;
        while (items_sent < $size(directed_rows) + RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                // Noise: any word at any index.
                send_write(12'($urandom), $urandom);
            else if (pick < 22)
                // Reshape the trie near the root, the root itself now and then.
                send_write(($urandom_range(0, 3) == 0) ? 12'd0 : 12'($urandom_range(0, 127)),
                           fresh_node_word($urandom_range(0, 2) == 0));
            else
            begin
                // Most lookups are steered along a real path; the rest are random.
                // Any entry the walk would read before it has been written is
                // filled first, then the final address is walked once more as is.
                addr    = $urandom;
                setr    = 1'($urandom);
                guiding = (pick < 85);
                forever
                begin
                    fin = walk_trie(addr, guiding, leaf_idx, gap_idx, gap_at_leaf);
                    if (gap_idx >= 0)
                        send_write(12'(gap_idx), fresh_node_word(gap_at_leaf));
                    else if (guiding)
                        guiding = 1'b0;
                    else
                        break;
                end
                send_item(KIND_LOOKUP, 12'($urandom), $urandom, addr, setr, 1'b0, WRITE_ACK);
            end
        end

        item_valid <= 1'b0;
        while (decodes_in_flight.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (decode_errors == 0)
            $display("PASS range_trie_address_decoder_unit");
        else
            $display("FAIL range_trie_address_decoder_unit");
        $finish;
    end

    // Result side: a random pause before each beat, with stretches of none, and
    // a pause of its own whenever the long hold below is in force.
    initial
    begin
        int gap;
        result_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = (rx_count % 50 < 12) ? 0 : $urandom_range(0, 8);
            if (gap > 0 || sink_hold)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
                while (sink_hold)
                    @(posedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_valid);
            rx_count++;
        end
    end

    // Once during the random part the result side refuses beats for a long
    // while, so that the queue fills and the block stops taking input.
    initial
    begin
        wait (random_phase);
        repeat ($urandom_range(40, 120)) @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    // Every accepted result beat is compared with the oldest decode in flight.
    always @(posedge clk)
    begin
        decode_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (decodes_in_flight.size() == 0)
            begin
                if (decode_errors < 10)
                    $display("unexpected result at %0t: status %0d code %h", $realtime,
                             status, leaf_code);
                decode_errors++;
            end
            else
            begin
                want = decodes_in_flight.pop_front();
                if (status !== want.status || leaf_code !== want.leaf_code ||
                    type_code !== want.type_code || func_item !== want.func_item ||
                    is_set !== want.is_set)
                begin
                    if (decode_errors < 10)
                        $display({"mismatch at %0t: status %0d/%0d code %h/%h type %h/%h ",
                                  "item %h/%h set %b/%b (expected/actual)"}, $realtime,
                                 want.status, status, want.leaf_code, leaf_code,
                                 want.type_code, type_code, want.func_item, func_item,
                                 want.is_set, is_set);
                    decode_errors++;
                end
            end
        end
    end

    // Watchdog: far beyond the slowest correct run, in which every beat walks
    // the full step limit behind the longest pauses on both sides.
    initial
    begin
        #8_000_000;
        $display("FAIL range_trie_address_decoder_unit");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/rtad_pkg.sv
hw/rtl/rtad_ram.sv
hw/rtl/rtad_front.sv
hw/rtl/rtad_queue.sv
hw/rtl/rtad_back.sv
hw/rtl/range_trie_address_decoder_unit.sv
test/tb_range_trie_address_decoder_unit.sv
